/* design/los_pkg.sv */
// shared types, widths and constants for the lane offset steering angle core
// no dependencies
package los_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int LHW_W        = 11;
    localparam int SPEED_W      = 7;
    localparam int STEER_W      = 16;
    localparam int CFG_DATA_W   = 11;

    // datapath widths, partly derived from the 16-bit coordinate width
    localparam int D_W          = COORD_WIDTH + 1;
    localparam int MAG_W        = COORD_WIDTH;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int NM_W         = LHW_W + MAG_W;
    localparam int SQ_N_W       = 50;
    localparam int ROOT_W       = SQ_N_W / 2;
    localparam int SQ_REM_W     = ROOT_W + 1;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int NUM_W        = 36;
    localparam int Q_W          = 12;
    localparam int DIV_STAGES   = Q_W;
    localparam int OFF_W        = Q_W + 1;
    localparam int P_W          = COORD_WIDTH + 2;
    localparam int SCALE_SH     = 52 - COORD_WIDTH;
    localparam int CX_W         = P_W + SCALE_SH + 2;
    localparam int Z_W          = 27;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [Z_W-1:0] DEG_HALF_TURN = 27'sd11796480;
    localparam logic signed [Z_W-1:0] DEG_QUARTER   = 27'sd5898240;
    localparam logic signed [Z_W-1:0] ROUND_BIAS    = 27'sd512;
    localparam int                    ANGLE_SH      = 10;
    localparam logic signed [Z_W-1:0] STEER_MIN     = -27'sd5760;
    localparam logic signed [Z_W-1:0] STEER_MAX     = 27'sd17280;

    typedef enum logic [0:0] {
        CFG_HALF_WIDTH  = 1'b0,
        CFG_DRIVE_SPEED = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                          line_valid;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } det_t;

    typedef struct packed {
        logic                      steer_update;
        logic signed [STEER_W-1:0] steering_angle;
        logic [SPEED_W-1:0]        motor_speed;
    } cmd_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = 27'sd2949120;
            1:       a = 27'sd1740967;
            2:       a = 27'sd919879;
            3:       a = 27'sd466945;
            4:       a = 27'sd234379;
            5:       a = 27'sd117304;
            6:       a = 27'sd58666;
            7:       a = 27'sd29335;
            8:       a = 27'sd14668;
            9:       a = 27'sd7334;
            10:      a = 27'sd3667;
            11:      a = 27'sd1833;
            12:      a = 27'sd917;
            13:      a = 27'sd458;
            14:      a = 27'sd229;
            15:      a = 27'sd115;
            16:      a = 27'sd57;
            17:      a = 27'sd29;
            18:      a = 27'sd14;
            19:      a = 27'sd7;
            20:      a = 27'sd4;
            21:      a = 27'sd2;
            22:      a = 27'sd1;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

/* design/los_sqrt_cell.sv */
// one cell of the pipelined square root: settles one root bit per cycle while en is high
// depends on los_pkg
module los_sqrt_cell #(
    parameter int TAG_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [los_pkg::SQ_N_W-1:0]   n_in,
    input  logic [los_pkg::ROOT_W-1:0]   root_in,
    input  logic [los_pkg::SQ_REM_W-1:0] rem_in,
    input  logic [TAG_W-1:0]             tag_in,
    output logic                         valid_out,
    output logic [los_pkg::SQ_N_W-1:0]   n_out,
    output logic [los_pkg::ROOT_W-1:0]   root_out,
    output logic [los_pkg::SQ_REM_W-1:0] rem_out,
    output logic [TAG_W-1:0]             tag_out
);

    logic                         valid_reg;
    logic [los_pkg::SQ_N_W-1:0]   n_reg, n_next;
    logic [los_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [los_pkg::SQ_REM_W-1:0] rem_reg, rem_next;
    logic [TAG_W-1:0]             tag_reg;
    logic [los_pkg::SQ_REM_W+1:0] pre;
    logic [los_pkg::SQ_REM_W+1:0] trial;

    always_comb
    begin
        pre    = {rem_in, n_in[los_pkg::SQ_N_W-1 -: 2]};
        trial  = (los_pkg::SQ_REM_W + 2)'({root_in, 2'b01});
        n_next = {n_in[los_pkg::SQ_N_W-3:0], 2'b00};
        if (pre >= trial)
        begin
            rem_next  = los_pkg::SQ_REM_W'(pre - trial);
            root_next = {root_in[los_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = los_pkg::SQ_REM_W'(pre);
            root_next = {root_in[los_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            tag_reg  <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign n_out     = n_reg;
    assign root_out  = root_reg;
    assign rem_out   = rem_reg;
    assign tag_out   = tag_reg;

endmodule

/* design/los_div_cell.sv */
// one cell of the pipelined dual divider: one quotient bit of both divisions
// depends on los_pkg
module los_div_cell #(
    parameter int BIT   = 0,
    parameter int TAG_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic [los_pkg::NUM_W-1:0]  rem_a_in,
    input  logic [los_pkg::NUM_W-1:0]  rem_b_in,
    input  logic [los_pkg::ROOT_W-1:0] div_in,
    input  logic [los_pkg::Q_W-1:0]    q_a_in,
    input  logic [los_pkg::Q_W-1:0]    q_b_in,
    input  logic [TAG_W-1:0]           tag_in,
    output logic                       valid_out,
    output logic [los_pkg::NUM_W-1:0]  rem_a_out,
    output logic [los_pkg::NUM_W-1:0]  rem_b_out,
    output logic [los_pkg::ROOT_W-1:0] div_out,
    output logic [los_pkg::Q_W-1:0]    q_a_out,
    output logic [los_pkg::Q_W-1:0]    q_b_out,
    output logic [TAG_W-1:0]           tag_out
);

    logic                       valid_reg;
    logic [los_pkg::NUM_W-1:0]  rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [los_pkg::ROOT_W-1:0] div_reg;
    logic [los_pkg::Q_W-1:0]    q_a_reg, q_a_next, q_b_reg, q_b_next;
    logic [TAG_W-1:0]           tag_reg;
    logic [los_pkg::NUM_W:0]    dsh;

    always_comb
    begin
        dsh        = (los_pkg::NUM_W + 1)'(div_in) << BIT;
        rem_a_next = rem_a_in;
        rem_b_next = rem_b_in;
        q_a_next   = q_a_in;
        q_b_next   = q_b_in;
        if ({1'b0, rem_a_in} >= dsh)
        begin
            rem_a_next    = los_pkg::NUM_W'({1'b0, rem_a_in} - dsh);
            q_a_next[BIT] = 1'b1;
        end
        if ({1'b0, rem_b_in} >= dsh)
        begin
            rem_b_next    = los_pkg::NUM_W'({1'b0, rem_b_in} - dsh);
            q_b_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            div_reg   <= div_in;
            q_a_reg   <= q_a_next;
            q_b_reg   <= q_b_next;
            tag_reg   <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_a_out = rem_a_reg;
    assign rem_b_out = rem_b_reg;
    assign div_out   = div_reg;
    assign q_a_out   = q_a_reg;
    assign q_b_out   = q_b_reg;
    assign tag_out   = tag_reg;

endmodule

/* design/los_cordic_cell.sv */
// one vectoring cordic cell: rotates toward the x axis by atan(2^-STAGE)
// depends on los_pkg
module los_cordic_cell #(
    parameter int STAGE = 0,
    parameter int TAG_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             valid_in,
    input  logic signed [los_pkg::CX_W-1:0]  x_in,
    input  logic signed [los_pkg::CX_W-1:0]  y_in,
    input  logic signed [los_pkg::Z_W-1:0]   z_in,
    input  logic [TAG_W-1:0]                 tag_in,
    output logic                             valid_out,
    output logic signed [los_pkg::CX_W-1:0]  x_out,
    output logic signed [los_pkg::CX_W-1:0]  y_out,
    output logic signed [los_pkg::Z_W-1:0]   z_out,
    output logic [TAG_W-1:0]                 tag_out
);

    logic                            valid_reg;
    logic signed [los_pkg::CX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [los_pkg::Z_W-1:0]  z_reg, z_next;
    logic [TAG_W-1:0]                tag_reg;
    logic signed [los_pkg::CX_W-1:0] xs, ys;
    logic signed [los_pkg::Z_W-1:0]  ang;
    logic                            y_pos;

    always_comb
    begin
        xs    = x_in >>> STAGE;
        ys    = y_in >>> STAGE;
        ang   = los_pkg::atan_entry(STAGE);
        y_pos = !y_in[los_pkg::CX_W-1] && (y_in != '0);
        if (y_pos)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign tag_out   = tag_reg;

endmodule

/* design/lane_offset_steering_angle_core.sv */
// top level of the lane offset steering angle core
// depends on los_pkg, los_sqrt_cell, los_div_cell, los_cordic_cell
//
// Takes one right lane line per transfer and returns one command per transfer: an invalid line
// gives speed 0 and no steering update; a valid line is offset by the half lane width along its
// left perpendicular and the steering angle is 90 degrees minus the angle of that point, in
// 1/64 degree. The core is a fully pipelined row of cells (25 square root cells, 12 divider
// cells, CORDIC_STAGES cordic cells), takes one line every cycle unless the output stalls, and
// runs stages b to d, square root, f, divider, g, h, cordic, output. A one-entry input buffer
// takes a line while a finished command waits at the output; det_stall rises only when full.
module lane_offset_steering_angle_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  los_pkg::cfg_index_t            cfg_index,
    input  logic [los_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           det_valid,
    output logic                           det_stall,
    input  los_pkg::det_t                  det,
    output logic                           cmd_valid,
    input  logic                           cmd_stall,
    output los_pkg::cmd_t                  cmd
);

    localparam int CW = los_pkg::COORD_WIDTH;

    typedef struct packed {
        logic                      lv;
        logic signed [CW-1:0]      sx;
        logic signed [CW-1:0]      sy;
        logic                      ox_neg;
        logic                      oy_neg;
        logic                      dzero;
        logic [los_pkg::NUM_W-1:0] num_x;
        logic [los_pkg::NUM_W-1:0] num_y;
    } sqrt_tag_t;

    typedef struct packed {
        logic                 lv;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic                 ox_neg;
        logic                 oy_neg;
        logic                 dzero;
    } div_tag_t;

    typedef struct packed {
        logic lv;
        logic pzero;
    } cordic_tag_t;

    localparam int SQ_TW = $bits(sqrt_tag_t);
    localparam int DV_TW = $bits(div_tag_t);
    localparam int CO_TW = $bits(cordic_tag_t);

    // configuration
    logic [los_pkg::LHW_W-1:0]   lhw_reg;
    logic [los_pkg::SPEED_W-1:0] speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lhw_reg   <= 11'd128;
            speed_reg <= 7'd25;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                los_pkg::CFG_HALF_WIDTH:  lhw_reg   <= cfg_data;
                los_pkg::CFG_DRIVE_SPEED: speed_reg <= cfg_data[los_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and input buffer
    logic          adv;
    logic          cmd_valid_reg;
    los_pkg::cmd_t cmd_reg, cmd_next;
    logic          skid_full_reg, skid_full_next;
    los_pkg::det_t skid_reg;
    logic          front_valid;
    los_pkg::det_t front;

    assign adv         = !cmd_valid_reg || !cmd_stall;
    assign front_valid = skid_full_reg || det_valid;
    assign front       = skid_full_reg ? skid_reg : det;

    always_comb
    begin
        if (adv)
            skid_full_next = 1'b0;
        else
            skid_full_next = skid_full_reg || det_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else
            skid_full_reg <= skid_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && det_valid && !adv)
            skid_reg <= det;
    end

    assign det_stall = skid_full_reg;

    // stage b: line direction
    logic                          b_valid_reg, b_lv_reg;
    logic signed [CW-1:0]          b_sx_reg, b_sy_reg;
    logic signed [los_pkg::D_W-1:0] b_dx_reg, b_dy_reg;

    // stage c: magnitudes and signs
    logic                          c_valid_reg, c_lv_reg;
    logic signed [CW-1:0]          c_sx_reg, c_sy_reg;
    logic [los_pkg::MAG_W-1:0]     c_ax_reg, c_ay_reg;
    logic                          c_ox_neg_reg, c_oy_neg_reg, c_dzero_reg;
    logic signed [los_pkg::D_W-1:0] c_nx, c_ny;

    // stage d: squares and scaled half widths
    logic                          d_valid_reg, d_lv_reg;
    logic signed [CW-1:0]          d_sx_reg, d_sy_reg;
    logic                          d_ox_neg_reg, d_oy_neg_reg, d_dzero_reg;
    logic [los_pkg::SQ_W-1:0]      d_sqx_reg, d_sqy_reg;
    logic [los_pkg::NM_W-1:0]      d_nmx_reg, d_nmy_reg;

    assign c_nx = -b_dx_reg;
    assign c_ny = -b_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= front_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_lv_reg <= front.line_valid;
            b_sx_reg <= front.start_x;
            b_sy_reg <= front.start_y;
            b_dx_reg <= {front.end_x[CW-1], front.end_x} - {front.start_x[CW-1], front.start_x};
            b_dy_reg <= {front.end_y[CW-1], front.end_y} - {front.start_y[CW-1], front.start_y};

            c_lv_reg     <= b_lv_reg;
            c_sx_reg     <= b_sx_reg;
            c_sy_reg     <= b_sy_reg;
            c_ax_reg     <= b_dx_reg[los_pkg::D_W-1] ? c_nx[los_pkg::MAG_W-1:0]
                                                     : b_dx_reg[los_pkg::MAG_W-1:0];
            c_ay_reg     <= b_dy_reg[los_pkg::D_W-1] ? c_ny[los_pkg::MAG_W-1:0]
                                                     : b_dy_reg[los_pkg::MAG_W-1:0];
            // x offset points against dy, y offset along dx
            c_ox_neg_reg <= !b_dy_reg[los_pkg::D_W-1] && (b_dy_reg != '0);
            c_oy_neg_reg <= b_dx_reg[los_pkg::D_W-1];
            c_dzero_reg  <= (b_dx_reg == '0) && (b_dy_reg == '0);

            d_lv_reg     <= c_lv_reg;
            d_sx_reg     <= c_sx_reg;
            d_sy_reg     <= c_sy_reg;
            d_ox_neg_reg <= c_ox_neg_reg;
            d_oy_neg_reg <= c_oy_neg_reg;
            d_dzero_reg  <= c_dzero_reg;
            d_sqx_reg    <= c_ax_reg * c_ax_reg;
            d_sqy_reg    <= c_ay_reg * c_ay_reg;
            d_nmx_reg    <= lhw_reg * c_ay_reg;
            d_nmy_reg    <= lhw_reg * c_ax_reg;
        end
    end

    // square root chain: |d| in Q.8
    logic                           sq_valid [0:los_pkg::SQRT_STAGES];
    logic [los_pkg::SQ_N_W-1:0]     sq_n     [0:los_pkg::SQRT_STAGES];
    logic [los_pkg::ROOT_W-1:0]     sq_root  [0:los_pkg::SQRT_STAGES];
    logic [los_pkg::SQ_REM_W-1:0]   sq_rem   [0:los_pkg::SQRT_STAGES];
    logic [SQ_TW-1:0]               sq_tag   [0:los_pkg::SQRT_STAGES];
    sqrt_tag_t                      sq_tag_in, sq_tag_end;
    logic [los_pkg::SQ_W:0]         len2;

    assign len2 = {1'b0, d_sqx_reg} + {1'b0, d_sqy_reg};

    always_comb
    begin
        sq_tag_in.lv     = d_lv_reg;
        sq_tag_in.sx     = d_sx_reg;
        sq_tag_in.sy     = d_sy_reg;
        sq_tag_in.ox_neg = d_ox_neg_reg;
        sq_tag_in.oy_neg = d_oy_neg_reg;
        sq_tag_in.dzero  = d_dzero_reg;
        sq_tag_in.num_x  = los_pkg::NUM_W'({d_nmx_reg, 8'b0});
        sq_tag_in.num_y  = los_pkg::NUM_W'({d_nmy_reg, 8'b0});
    end

    assign sq_valid[0] = d_valid_reg;
    assign sq_n[0]     = los_pkg::SQ_N_W'({len2, 16'b0});
    assign sq_root[0]  = '0;
    assign sq_rem[0]   = '0;
    assign sq_tag[0]   = sq_tag_in;

    for (genvar i = 0; i < los_pkg::SQRT_STAGES; i++)
    begin : g_sqrt
        los_sqrt_cell #(
            .TAG_W (SQ_TW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (sq_valid[i]),
            .n_in      (sq_n[i]),
            .root_in   (sq_root[i]),
            .rem_in    (sq_rem[i]),
            .tag_in    (sq_tag[i]),
            .valid_out (sq_valid[i+1]),
            .n_out     (sq_n[i+1]),
            .root_out  (sq_root[i+1]),
            .rem_out   (sq_rem[i+1]),
            .tag_out   (sq_tag[i+1])
        );
    end

    assign sq_tag_end = sqrt_tag_t'(sq_tag[los_pkg::SQRT_STAGES]);

    // stage f: rounding bias added to the numerators
    logic                       f_valid_reg;
    logic [los_pkg::NUM_W-1:0]  f_num_x_reg, f_num_y_reg;
    logic [los_pkg::ROOT_W-1:0] f_root_reg;
    div_tag_t                   f_tag_reg;
    logic [los_pkg::NUM_W-1:0]  half_root;

    assign half_root = los_pkg::NUM_W'(sq_root[los_pkg::SQRT_STAGES][los_pkg::ROOT_W-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= sq_valid[los_pkg::SQRT_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_num_x_reg      <= sq_tag_end.num_x + half_root;
            f_num_y_reg      <= sq_tag_end.num_y + half_root;
            f_root_reg       <= sq_root[los_pkg::SQRT_STAGES];
            f_tag_reg.lv     <= sq_tag_end.lv;
            f_tag_reg.sx     <= sq_tag_end.sx;
            f_tag_reg.sy     <= sq_tag_end.sy;
            f_tag_reg.ox_neg <= sq_tag_end.ox_neg;
            f_tag_reg.oy_neg <= sq_tag_end.oy_neg;
            f_tag_reg.dzero  <= sq_tag_end.dzero;
        end
    end

    // divider chain: offset magnitudes
    logic                       dv_valid [0:los_pkg::DIV_STAGES];
    logic [los_pkg::NUM_W-1:0]  dv_rem_a [0:los_pkg::DIV_STAGES];
    logic [los_pkg::NUM_W-1:0]  dv_rem_b [0:los_pkg::DIV_STAGES];
    logic [los_pkg::ROOT_W-1:0] dv_div   [0:los_pkg::DIV_STAGES];
    logic [los_pkg::Q_W-1:0]    dv_q_a   [0:los_pkg::DIV_STAGES];
    logic [los_pkg::Q_W-1:0]    dv_q_b   [0:los_pkg::DIV_STAGES];
    logic [DV_TW-1:0]           dv_tag   [0:los_pkg::DIV_STAGES];
    div_tag_t                   dv_tag_end;

    assign dv_valid[0] = f_valid_reg;
    assign dv_rem_a[0] = f_num_x_reg;
    assign dv_rem_b[0] = f_num_y_reg;
    assign dv_div[0]   = f_root_reg;
    assign dv_q_a[0]   = '0;
    assign dv_q_b[0]   = '0;
    assign dv_tag[0]   = f_tag_reg;

    for (genvar i = 0; i < los_pkg::DIV_STAGES; i++)
    begin : g_div
        los_div_cell #(
            .BIT   (los_pkg::DIV_STAGES - 1 - i),
            .TAG_W (DV_TW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (dv_valid[i]),
            .rem_a_in  (dv_rem_a[i]),
            .rem_b_in  (dv_rem_b[i]),
            .div_in    (dv_div[i]),
            .q_a_in    (dv_q_a[i]),
            .q_b_in    (dv_q_b[i]),
            .tag_in    (dv_tag[i]),
            .valid_out (dv_valid[i+1]),
            .rem_a_out (dv_rem_a[i+1]),
            .rem_b_out (dv_rem_b[i+1]),
            .div_out   (dv_div[i+1]),
            .q_a_out   (dv_q_a[i+1]),
            .q_b_out   (dv_q_b[i+1]),
            .tag_out   (dv_tag[i+1])
        );
    end

    assign dv_tag_end = div_tag_t'(dv_tag[los_pkg::DIV_STAGES]);

    // stage g: offset point
    logic                            g_valid_reg, g_lv_reg;
    logic signed [los_pkg::P_W-1:0]  g_px_reg, g_py_reg;
    logic [los_pkg::Q_W-1:0]         qx, qy;
    logic signed [los_pkg::OFF_W-1:0] ox, oy;

    always_comb
    begin
        // a zero-length line has no perpendicular
        qx = dv_tag_end.dzero ? '0 : dv_q_a[los_pkg::DIV_STAGES];
        qy = dv_tag_end.dzero ? '0 : dv_q_b[los_pkg::DIV_STAGES];
        ox = dv_tag_end.ox_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        oy = dv_tag_end.oy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (adv)
            g_valid_reg <= dv_valid[los_pkg::DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_lv_reg <= dv_tag_end.lv;
            g_px_reg <= {{(los_pkg::P_W - CW){dv_tag_end.sx[CW-1]}}, dv_tag_end.sx}
                      + {{(los_pkg::P_W - los_pkg::OFF_W){ox[los_pkg::OFF_W-1]}}, ox};
            g_py_reg <= {{(los_pkg::P_W - CW){dv_tag_end.sy[CW-1]}}, dv_tag_end.sy}
                      + {{(los_pkg::P_W - los_pkg::OFF_W){oy[los_pkg::OFF_W-1]}}, oy};
        end
    end

    // stage h: scale and fold the left half plane by 180 degrees
    localparam int XPAD = los_pkg::CX_W - los_pkg::P_W - los_pkg::SCALE_SH;

    logic                            h_valid_reg;
    logic signed [los_pkg::CX_W-1:0] h_x_reg, h_y_reg;
    logic signed [los_pkg::Z_W-1:0]  h_z_reg;
    cordic_tag_t                     h_tag_reg;
    logic signed [los_pkg::CX_W-1:0] sc_x, sc_y;
    logic                            x_neg;

    always_comb
    begin
        sc_x  = {{XPAD{g_px_reg[los_pkg::P_W-1]}}, g_px_reg, {los_pkg::SCALE_SH{1'b0}}};
        sc_y  = {{XPAD{g_py_reg[los_pkg::P_W-1]}}, g_py_reg, {los_pkg::SCALE_SH{1'b0}}};
        x_neg = g_px_reg[los_pkg::P_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (adv)
            h_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_x_reg         <= x_neg ? -sc_x : sc_x;
            h_y_reg         <= x_neg ? -sc_y : sc_y;
            h_z_reg         <= !x_neg ? '0
                             : (g_py_reg[los_pkg::P_W-1] ? -los_pkg::DEG_HALF_TURN
                                                         : los_pkg::DEG_HALF_TURN);
            h_tag_reg.lv    <= g_lv_reg;
            h_tag_reg.pzero <= (g_px_reg == '0) && (g_py_reg == '0);
        end
    end

    // cordic chain
    logic                            co_valid [0:CORDIC_STAGES];
    logic signed [los_pkg::CX_W-1:0] co_x     [0:CORDIC_STAGES];
    logic signed [los_pkg::CX_W-1:0] co_y     [0:CORDIC_STAGES];
    logic signed [los_pkg::Z_W-1:0]  co_z     [0:CORDIC_STAGES];
    logic [CO_TW-1:0]                co_tag   [0:CORDIC_STAGES];
    cordic_tag_t                     co_tag_end;

    assign co_valid[0] = h_valid_reg;
    assign co_x[0]     = h_x_reg;
    assign co_y[0]     = h_y_reg;
    assign co_z[0]     = h_z_reg;
    assign co_tag[0]   = h_tag_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        los_cordic_cell #(
            .STAGE (i),
            .TAG_W (CO_TW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (co_valid[i]),
            .x_in      (co_x[i]),
            .y_in      (co_y[i]),
            .z_in      (co_z[i]),
            .tag_in    (co_tag[i]),
            .valid_out (co_valid[i+1]),
            .x_out     (co_x[i+1]),
            .y_out     (co_y[i+1]),
            .z_out     (co_z[i+1]),
            .tag_out   (co_tag[i+1])
        );
    end

    assign co_tag_end = cordic_tag_t'(co_tag[CORDIC_STAGES]);

    // output register: steering = round((90 deg - angle) / 1024), clamped
    logic signed [los_pkg::Z_W-1:0] zf, vf, st;

    always_comb
    begin
        // point at the origin has angle zero
        zf = co_tag_end.pzero ? '0 : co_z[CORDIC_STAGES];
        vf = los_pkg::DEG_QUARTER - zf + los_pkg::ROUND_BIAS;
        st = vf >>> los_pkg::ANGLE_SH;
        if (st < los_pkg::STEER_MIN)
            st = los_pkg::STEER_MIN;
        else if (st > los_pkg::STEER_MAX)
            st = los_pkg::STEER_MAX;
        cmd_next = '0;
        if (co_tag_end.lv)
        begin
            cmd_next.steer_update   = 1'b1;
            cmd_next.steering_angle = st[los_pkg::STEER_W-1:0];
            cmd_next.motor_speed    = speed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (adv)
            cmd_valid_reg <= co_valid[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

`ifndef ASSERT_OFF
    a_invalid_line_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd.steer_update |-> cmd.steering_angle == '0 && cmd.motor_speed == '0)
        else $error("invalid line produced a nonzero command");

    a_steer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.steer_update |->
            $signed(cmd.steering_angle) >= -16'sd5760 && $signed(cmd.steering_angle) <= 16'sd17280)
        else $error("steering angle outside its limits");

    a_buffer_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !adv |=> skid_full_reg)
        else $error("input buffer dropped a line while the pipeline was held");
`endif

endmodule

/* test/los_checker.sv */
// result checker for the lane offset steering angle core: predicts each command from
// observed line transfers and register writes, and compares it with the command transfers
// depends on los_pkg
`timescale 1ns / 100ps

module los_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  los_pkg::cfg_index_t             cfg_index,
    input  logic [los_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            det_valid,
    input  logic                            det_stall,
    input  los_pkg::det_t                   det,
    input  logic                            cmd_valid,
    input  logic                            cmd_stall,
    input  los_pkg::cmd_t                   cmd,
    output int                              errors,
    output int                              pending
);

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_DEG [los_pkg::ATAN_ENTRIES] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic [los_pkg::LHW_W-1:0]   half_width;
    logic [los_pkg::SPEED_W-1:0] speed;
    los_pkg::cmd_t               cmd_fifo[$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // quotient rounded to nearest, halves away from zero
    function automatic longint round_div(input longint n, input longint d);
        longint mag, q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    // angle of (px, py) in 2^-16 degree
    function automatic longint point_angle(input longint px, input longint py);
        longint x, y, z, xs, ys;
        z = 0;
        if (px == 0 && py == 0)
            return 0;
        x = px <<< los_pkg::SCALE_SH;
        y = py <<< los_pkg::SCALE_SH;
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < los_pkg::ATAN_ENTRIES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z += ATAN_DEG[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= ATAN_DEG[i];
            end
        end
        return z;
    endfunction

    function automatic los_pkg::cmd_t steer_command(input los_pkg::det_t d,
                                                    input logic [los_pkg::LHW_W-1:0] hw,
                                                    input logic [los_pkg::SPEED_W-1:0] spd);
        los_pkg::cmd_t c;
        longint        sx, sy, dx, dy, ox, oy, r, st;
        c = '0;
        if (!d.line_valid)
            return c;
        sx = longint'(d.start_x);
        sy = longint'(d.start_y);
        dx = longint'(d.end_x) - sx;
        dy = longint'(d.end_y) - sy;
        ox = 0;
        oy = 0;
        while (dx >= (64'sd1 <<< 20) || dx <= -(64'sd1 <<< 20)
               || dy >= (64'sd1 <<< 20) || dy <= -(64'sd1 <<< 20))
        begin
            dx = dx >>> 1;
            dy = dy >>> 1;
        end
        if (dx != 0 || dy != 0)
        begin
            r = longint'(int_sqrt(longint'(dx * dx + dy * dy) << 16));
            if (r > 0)
            begin
                ox = -round_div(longint'(hw) * dy * 256, r);
                oy = round_div(longint'(hw) * dx * 256, r);
            end
        end
        st = (90 * 65536 - point_angle(sx + ox, sy + oy) + 512) >>> 10;
        if (st < -5760)
            st = -5760;
        if (st > 17280)
            st = 17280;
        c.steer_update   = 1'b1;
        c.steering_angle = st[los_pkg::STEER_W-1:0];
        c.motor_speed    = spd;
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        los_pkg::cmd_t want;
        if (!rst_n)
        begin
            half_width <= 11'd128;
            speed      <= 7'd25;
            errors     <= 0;
            cmd_fifo.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == los_pkg::CFG_HALF_WIDTH)
                    half_width <= cfg_data[los_pkg::LHW_W-1:0];
                else if (cfg_index == los_pkg::CFG_DRIVE_SPEED)
                    speed <= cfg_data[los_pkg::SPEED_W-1:0];
            end
            if (det_valid && !det_stall)
                cmd_fifo.push_back(steer_command(det, half_width, speed));
            if (cmd_valid && !cmd_stall)
            begin
                if (cmd_fifo.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: command transfer with none expected: %p", $realtime, cmd);
                    errors <= errors + 1;
                end
                else
                begin
                    want = cmd_fifo.pop_front();
                    if (want !== cmd)
                    begin
                        if (errors < 10)
                            $display("%0t: command mismatch upd %b/%b angle %0d/%0d speed %0d/%0d",
                                     $realtime, want.steer_update, cmd.steer_update,
                                     want.steering_angle, cmd.steering_angle,
                                     want.motor_speed, cmd.motor_speed);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = cmd_fifo.size();

endmodule

/* test/tb.sv */
// testbench top for the lane offset steering angle core: clock, reset, line and
// register stimulus, output stall bursts and the verdict
// depends on los_pkg, lane_offset_steering_angle_core and los_checker
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY   = 60;
    localparam int CYCLE_MAX = 400000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    los_pkg::cfg_index_t            cfg_index;
    logic [los_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           det_valid;
    logic                           det_stall;
    los_pkg::det_t                  det;
    logic                           cmd_valid;
    logic                           cmd_stall = 1'b0;
    los_pkg::cmd_t                  cmd;
    int                             errors;
    int                             pending;
    int                             cycles = 0;
    int                             lines_sent;
    int                             stall_left = 0;
    logic                           quiet;

    lane_offset_steering_angle_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .det_valid (det_valid),
        .det_stall (det_stall),
        .det       (det),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    los_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .det_valid (det_valid),
        .det_stall (det_stall),
        .det       (det),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;
    always
        #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side stall bursts
    always @(posedge clk)
    begin
        if (quiet)
            cmd_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            cmd_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            cmd_stall  <= 1'b1;
        end
        else
            cmd_stall <= 1'b0;
    end

    task automatic write_reg(input los_pkg::cfg_index_t idx,
                             input logic [los_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        det_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // valid stays high from one transfer to the next unless a gap is drawn
    task automatic send_line(input los_pkg::det_t d);
        logic stalled;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            det_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        det_valid <= 1'b1;
        det       <= d;
        do
        begin
            @(negedge clk);
            stalled = det_stall;
            @(posedge clk);
        end
        while (stalled);
        lines_sent++;
    endtask

    function automatic logic [los_pkg::COORD_WIDTH-1:0] rand_coord(input bit near);
        if (near)
            return los_pkg::COORD_WIDTH'($urandom_range(0, 2047)) - 16'd1024;
        return los_pkg::COORD_WIDTH'($urandom);
    endfunction

    function automatic los_pkg::det_t rand_line();
        los_pkg::det_t d;
        bit            near;
        near         = $urandom_range(0, 1);
        d.line_valid = ($urandom_range(0, 9) != 0);
        d.start_x    = rand_coord(near);
        d.start_y    = rand_coord(near);
        d.end_x      = rand_coord(near);
        d.end_y      = rand_coord(near);
        if ($urandom_range(0, 19) == 0)
        begin
            d.end_x = d.start_x;
            d.end_y = d.start_y;
        end
        return d;
    endfunction

    function automatic los_pkg::det_t make_line(input logic v, input int sx, input int sy,
                                                input int ex, input int ey);
        los_pkg::det_t d;
        d.line_valid = v;
        d.start_x    = sx[los_pkg::COORD_WIDTH-1:0];
        d.start_y    = sy[los_pkg::COORD_WIDTH-1:0];
        d.end_x      = ex[los_pkg::COORD_WIDTH-1:0];
        d.end_y      = ey[los_pkg::COORD_WIDTH-1:0];
        return d;
    endfunction

    initial
    begin
        logic [los_pkg::CFG_DATA_W-1:0] widths [5];
        logic [los_pkg::CFG_DATA_W-1:0] speeds [5];
        widths = '{11'd128, 11'd0, 11'd2047, 11'd1024, 11'd37};
        speeds = '{11'd25, 11'd0, 11'd127, 11'd100, 11'd1};
        lines_sent = 0;
        quiet      = 1'b0;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= los_pkg::CFG_HALF_WIDTH;
        cfg_data   <= '0;
        det_valid  <= 1'b0;
        det        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines at reset settings
        send_line(make_line(1'b0, 1000, -200, 3000, 400));
        send_line(make_line(1'b0, -1, -1, -1, -1));
        send_line(make_line(1'b1, 0, 0, 0, 0));
        send_line(make_line(1'b1, 0, 0, 0, 256));
        send_line(make_line(1'b1, 512, 256, 512, 256));
        send_line(make_line(1'b1, -512, 300, -512, 300));
        send_line(make_line(1'b1, -512, -300, -512, -300));
        send_line(make_line(1'b1, 0, -300, 0, -300));
        send_line(make_line(1'b1, -300, 0, -300, 0));
        send_line(make_line(1'b1, 32767, 32767, -32768, -32768));
        send_line(make_line(1'b1, -32768, -32768, 32767, 32767));
        send_line(make_line(1'b1, -32768, 32767, 32767, -32768));
        send_line(make_line(1'b1, 32767, -32768, -32768, 32767));
        send_line(make_line(1'b1, 256, 0, 256, 2560));
        send_line(make_line(1'b1, 256, 0, 256, -2560));
        send_line(make_line(1'b1, -128, 0, -128, 2560));
        send_line(make_line(1'b1, 128, -64, 128, -1));
        send_line(make_line(1'b1, -32768, 0, -32768, 1));
        send_line(make_line(1'b1, 1, 1, 2, 2));

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(los_pkg::CFG_HALF_WIDTH, widths[ph]);
            write_reg(los_pkg::CFG_DRIVE_SPEED, speeds[ph]);
            send_line(make_line(1'b1, 0, 0, 0, 0));
            send_line(make_line(1'b1, 100, -100, 100, 900));
            for (int k = 0; k < 200; k++)
            begin
                if (ph == 4 && k >= 120)
                    quiet = 1'b1;
                send_line(rand_line());
            end
        end

        drain();
        $display("%0d line transfers over five register settings, half width 0..2047",
                 lines_sent);
        $display("speed 0..127, with random gaps and output stalls; %0d mismatches", errors);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
design/los_pkg.sv
design/los_sqrt_cell.sv
design/los_div_cell.sv
design/los_cordic_cell.sv
design/lane_offset_steering_angle_core.sv
test/los_checker.sv
test/tb.sv
